/* rtl/vs2d_pkg.sv */
// ----------------------------------------------------------------------------
// vs2d_pkg: shared types and constants of the vorticity stencil
// Field widths, register indexes and the per-request control record that
// travels from the raster counters to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package vs2d_pkg;

	// Field widths fixed by the stream format.
	localparam int VEL_W  = 18;
	localparam int CURL_W = 20;
	localparam int POS_W  = 10;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 2;

	// Reset value of both frame dimension registers.
	localparam int DIM_RESET = 1024;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Raster position and border flags of one accepted request.
	typedef struct packed {
		logic             last_col;
		logic             last_row;
		logic             single_row;
		logic             first_row;
		logic             interior;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} item_ctl_t;

endpackage

`default_nettype wire

/* rtl/vs2d_rowmem.sv */
// ----------------------------------------------------------------------------
// vs2d_rowmem: row stores of the vorticity stencil
// Two rows of x velocity (slot by row parity) and one row of y velocity.
// Each accepted request reads the old entries and writes its own values at
// the same edge; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vs2d_rowmem #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                                   clk,
	input  wire                                   wr_en,
	input  wire                                   row_par,
	input  wire  [$clog2(MAX_WIDTH)-1:0]          col,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     vel_x,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     vel_y,
	output logic signed [vs2d_pkg::VEL_W-1:0]     ux_up_s1,
	output logic signed [vs2d_pkg::VEL_W-1:0]     uy_above_s1,
	output logic signed [vs2d_pkg::VEL_W-1:0]     uy_right_s1
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int XAW = $clog2(2 * MAX_WIDTH);

	logic signed [vs2d_pkg::VEL_W-1:0] xmem [0:2*MAX_WIDTH-1];
	logic signed [vs2d_pkg::VEL_W-1:0] ymem [0:MAX_WIDTH-1];

	logic [XAW-1:0] xaddr;
	logic [XW-1:0]  col_right;

	// The x row slot is chosen by row parity; the right neighbor wraps.
	always_comb begin
		xaddr     = row_par ? (XAW'(MAX_WIDTH) + XAW'(col)) : XAW'(col);
		col_right = (col == XW'(MAX_WIDTH - 1)) ? '0 : col + XW'(1);
	end

	// Read old contents, then overwrite with the current request.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ux_up_s1    <= xmem[xaddr];
			uy_above_s1 <= ymem[col];
			uy_right_s1 <= ymem[col_right];
			xmem[xaddr] <= vel_x;
			ymem[col]   <= vel_y;
		end
	end

endmodule

`default_nettype wire

/* rtl/vs2d_emit.sv */
// ----------------------------------------------------------------------------
// vs2d_emit: curl datapath and result sequencing
// Holds one request in stage 1 beside the row store read data, forms the
// curl and hands none, one or two results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vs2d_emit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   accept,
	input  wire  vs2d_pkg::item_ctl_t             ctl,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     vel_x,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     ux_up_s1,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     uy_above_s1,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     uy_right_s1,
	output logic                                  busy,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [vs2d_pkg::CURL_W-1:0]    curl_value,
	output logic [vs2d_pkg::POS_W-1:0]            cell_row,
	output logic [vs2d_pkg::POS_W-1:0]            cell_col,
	output logic                                  frame_end,
	output logic                                  run_last
);

	localparam int CW = vs2d_pkg::CURL_W;
	localparam int PW = vs2d_pkg::POS_W;

	// Stage 1 request.
	logic                              valid_s1;
	logic                              second_s1;
	vs2d_pkg::item_ctl_t               ctl_s1;
	logic signed [vs2d_pkg::VEL_W-1:0] vx_s1;

	// Previous-row y velocity one column to the left.
	logic signed [vs2d_pkg::VEL_W-1:0] uy_left_q;

	// Output register.
	logic                              out_valid_q;
	logic signed [CW-1:0]              curl_q;
	logic [PW-1:0]                     row_q;
	logic [PW-1:0]                     col_q;
	logic                              fend_q;
	logic                              last_q;

	logic                              silent;
	logic                              last_res;
	logic                              out_free;
	logic                              load_out;
	logic                              done_s1;
	logic signed [CW-1:0]              diff_y;
	logic signed [CW-1:0]              diff_x;
	logic signed [CW-1:0]              curl;
	logic signed [CW-1:0]              res_curl;
	logic [PW-1:0]                     res_row;
	logic                              res_fend;

	// Central differences; the extra fraction bit makes the halving exact.
	always_comb begin
		diff_y = CW'(uy_right_s1) - CW'(uy_left_q);
		diff_x = CW'(vx_s1) - CW'(ux_up_s1);
		curl   = ctl_s1.interior ? (diff_y - diff_x) : '0;
	end

	// Pick the result this cycle and decide when the stage frees up.
	always_comb begin
		silent   = ctl_s1.first_row && !ctl_s1.single_row;
		last_res = ctl_s1.single_row || second_s1 || !ctl_s1.last_row;
		out_free = !out_valid_q || !out_stall;
		load_out = valid_s1 && !silent && out_free;
		done_s1  = valid_s1 && (silent || (out_free && last_res));
		busy     = valid_s1 && !done_s1;
		if (ctl_s1.single_row || second_s1) begin
			res_curl = '0;
			res_row  = ctl_s1.row;
			res_fend = ctl_s1.last_col;
		end else begin
			res_curl = curl;
			res_row  = ctl_s1.row - PW'(1);
			res_fend = 1'b0;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			second_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				second_s1 <= 1'b0;
			end else if (done_s1) begin
				valid_s1  <= 1'b0;
				second_s1 <= 1'b0;
			end else if (load_out) begin
				second_s1 <= 1'b1;
			end
		end
	end

	// Stage 1 payload and the left neighbor.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			vx_s1  <= vel_x;
		end
		if (done_s1) begin
			uy_left_q <= uy_above_s1;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			curl_q <= res_curl;
			row_q  <= res_row;
			col_q  <= ctl_s1.col;
			fend_q <= res_fend;
			last_q <= last_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign curl_value = curl_q;
	assign cell_row   = row_q;
	assign cell_col   = col_q;
	assign frame_end  = fend_q;
	assign run_last   = last_q;

`ifndef SYNTHESIS
	// The second result only exists for final-row requests of a tall frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		second_s1 |-> (valid_s1 && ctl_s1.last_row && !ctl_s1.single_row))
		else $error("second result pending on a request without one");

	// The end of a frame always closes the results of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fend_q) |-> last_q)
		else $error("frame end on a result that is not the last of its request");

	// A new request always lands in stage 1 as a fresh first result.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid_s1 && !second_s1))
		else $error("accepted request not held in stage 1");
`endif

endmodule

`default_nettype wire

/* rtl/vorticity_stencil_2d.sv */
// ----------------------------------------------------------------------------
// vorticity_stencil_2d: streaming 2-D curl stencil with central differences
// Takes cell velocities in raster order and gives the halved curl of every
// interior cell one row late, zero on border cells.
//
//   channel   direction   handshake              payload
//   in        request in  in_valid / in_stall    vel_x, vel_y
//   out       result out  out_valid / out_stall  curl_value, cell_row,
//                                                cell_col, frame_end, run_last
//   cfg       write in    cfg_write              cfg_addr, cfg_wdata
//
// One request per cycle while the output does not stall; requests of the final
// row hold the input while both of their results pass through the single output register.
// Row stores are read and written at the accept edge and their read data
// feeds stage 1, so the first result of a request passes from stage 1 to the
// output register once the output register is free.
// Reset clears counters and control and loads the frame dimension registers only;
// row stores need no clearing pass, since an interior result only uses entries written earlier in its frame.
// A stalled output holds one result while stage 1 still takes one request.
// ----------------------------------------------------------------------------
`default_nettype none

module vorticity_stencil_2d #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     vel_x,
	input  wire  signed [vs2d_pkg::VEL_W-1:0]     vel_y,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [vs2d_pkg::CURL_W-1:0]    curl_value,
	output logic [vs2d_pkg::POS_W-1:0]            cell_row,
	output logic [vs2d_pkg::POS_W-1:0]            cell_col,
	output logic                                  frame_end,
	output logic                                  run_last,
	input  wire                                   cfg_write,
	input  wire  [vs2d_pkg::IDX_W-1:0]            cfg_addr,
	input  wire  [vs2d_pkg::CFG_W-1:0]            cfg_wdata
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WM1_RESET =
		((MAX_WIDTH < vs2d_pkg::DIM_RESET) ? MAX_WIDTH : vs2d_pkg::DIM_RESET) - 1;
	localparam int HM1_RESET =
		((MAX_HEIGHT < vs2d_pkg::DIM_RESET) ? MAX_HEIGHT : vs2d_pkg::DIM_RESET) - 1;

	logic [XW-1:0]       wm1_q;
	logic [YW-1:0]       hm1_q;
	logic [XW-1:0]       col_q;
	logic [YW-1:0]       row_q;
	logic                accept;
	logic                busy;
	logic                last_col;
	logic                last_row;
	logic [XW-1:0]       cfg_wm1;
	logic [YW-1:0]       cfg_hm1;
	vs2d_pkg::item_ctl_t ctl;

	logic signed [vs2d_pkg::VEL_W-1:0] ux_up_s1;
	logic signed [vs2d_pkg::VEL_W-1:0] uy_above_s1;
	logic signed [vs2d_pkg::VEL_W-1:0] uy_right_s1;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	// Clamp a written dimension to 1 .. maximum and keep it minus one.
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_wm1 = '0;
		end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
			cfg_wm1 = XW'(MAX_WIDTH - 1);
		end else begin
			cfg_wm1 = XW'(cfg_wdata - vs2d_pkg::CFG_W'(1));
		end
		if (cfg_wdata == '0) begin
			cfg_hm1 = '0;
		end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
			cfg_hm1 = YW'(MAX_HEIGHT - 1);
		end else begin
			cfg_hm1 = YW'(cfg_wdata - vs2d_pkg::CFG_W'(1));
		end
	end

	// Border flags of the cell at the raster position.
	always_comb begin
		last_col       = (col_q == wm1_q);
		last_row       = (row_q == hm1_q);
		ctl.last_col   = last_col;
		ctl.last_row   = last_row;
		ctl.single_row = (hm1_q == '0);
		ctl.first_row  = (row_q == '0);
		ctl.interior   = (row_q > YW'(1)) && (col_q != '0) && (col_q < wm1_q);
		ctl.row        = vs2d_pkg::POS_W'(row_q);
		ctl.col        = vs2d_pkg::POS_W'(col_q);
	end

	// Frame registers and raster counters; a write to either frame register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= XW'(WM1_RESET);
			hm1_q <= YW'(HM1_RESET);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write) begin
			case (cfg_addr)
				vs2d_pkg::REG_FRAME_WIDTH: begin
					wm1_q <= cfg_wm1;
					col_q <= '0;
					row_q <= '0;
				end
				vs2d_pkg::REG_FRAME_HEIGHT: begin
					hm1_q <= cfg_hm1;
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	vs2d_rowmem #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_rowmem (
		.clk         (clk),
		.wr_en       (accept),
		.row_par     (row_q[0]),
		.col         (col_q),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.ux_up_s1    (ux_up_s1),
		.uy_above_s1 (uy_above_s1),
		.uy_right_s1 (uy_right_s1)
	);

	vs2d_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ctl         (ctl),
		.vel_x       (vel_x),
		.ux_up_s1    (ux_up_s1),
		.uy_above_s1 (uy_above_s1),
		.uy_right_s1 (uy_right_s1),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.curl_value  (curl_value),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.frame_end   (frame_end),
		.run_last    (run_last)
	);

`ifndef SYNTHESIS
	// The raster position never leaves the configured frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wm1_q) && (row_q <= hm1_q))
		else $error("raster position outside the frame");

	// The last request of a frame wraps both counters to the origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && last_row && !cfg_write) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at the end of the frame");
`endif

endmodule

`default_nettype wire
